// File: rtl/gs1d_pkg.sv
// ---------------------------------------------------------------------------
// gs1d_pkg
// Shared types and constants for the 1D Gauss-Seidel Poisson solver.
// ---------------------------------------------------------------------------
package gs1d_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_MAX_SWEEPS    = 2'd0;
    localparam logic [1:0] CFG_STEP_SQUARED  = 2'd1;
    localparam logic [1:0] CFG_INV_STEP_SQ   = 2'd2;

    localparam logic [15:0] MAX_SWEEPS_RST   = 16'd1000;
    localparam logic [31:0] STEP_SQ_RST      = 32'd1040025;
    localparam logic [23:0] INV_STEP_SQ_RST  = 24'd4225;

    localparam logic [47:0] RES_MAX          = 48'hFFFF_FFFF_FFFF;

    // Datapath operation codes issued by the controller.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_RES   = 3'd2;
    localparam logic [2:0] OP_SWEEP = 3'd3;
    localparam logic [2:0] OP_EMIT  = 3'd4;

    // Command from controller to datapath.
    typedef struct packed {
        logic [2:0] op;
        logic [5:0] idx;
        logic       clr_sum;
    } gs1d_cmd_t;

endpackage

// File: rtl/gs1d_datapath.sv
// ---------------------------------------------------------------------------
// gs1d_datapath
// Point stores plus the sweep and residual arithmetic, one point per pass.
// ---------------------------------------------------------------------------
module gs1d_datapath
    import gs1d_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  gs1d_cmd_t         cmd,
    input  logic [6:0]        n_pts,
    input  logic signed [31:0] rhs_in,
    input  logic [31:0]       step_sq,
    input  logic [23:0]       inv_step_sq,
    output logic              done,
    output logic signed [31:0] x_out,
    output logic [47:0]       res_sum
);

    localparam int AW = $clog2(MAX_POINTS);

    logic signed [31:0] rhs_mem [MAX_POINTS];
    logic signed [31:0] x_mem   [MAX_POINTS];

    // Pass steps: 0 read center and left, 1 read right and sweep multiply,
    // 2 residual multiply, 3 write and residual term, 4 partial squares,
    // 5 square, 6 accumulate.
    logic [2:0]  ph_reg, ph_next;
    logic [AW-1:0] ai;
    logic [AW-1:0] nb_addr;
    logic signed [31:0] rhs_r, xc_r, xl_r, xr_r;
    logic signed [63:0] prod_reg;
    logic signed [63:0] t_reg;
    logic signed [63:0] t_abs;
    logic [19:0] t_hi, t_lo;
    logic [39:0] hh_reg, hl_reg, ll_reg;
    logic        sat_reg;
    logic [61:0] mid_v;
    logic [47:0] sq_reg;
    logic [47:0] sum_reg;
    logic signed [31:0] x_new;
    logic is_first, is_last;

    assign ai       = cmd.idx[AW-1:0];
    assign is_first = (cmd.idx == 6'd0);
    assign is_last  = ({1'b0, cmd.idx} + 7'd1 == n_pts);
    // The neighbor port reads the left point first, then the right one.
    assign nb_addr  = (ph_reg == 3'd0) ? AW'(cmd.idx - 6'd1) : AW'(cmd.idx + 6'd1);

    // Memory writes and registered reads.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            rhs_mem[ai] <= rhs_in;
            x_mem[ai]   <= '0;
        end else if (cmd.op == OP_SWEEP && ph_reg == 3'd3) begin
            x_mem[ai] <= x_new;
        end
        rhs_r <= rhs_mem[ai];
        xc_r  <= x_mem[ai];
        if (ph_reg == 3'd0) xl_r <= is_first ? 32'sd0 : x_mem[nb_addr];
        if (ph_reg == 3'd1) xr_r <= is_last  ? 32'sd0 : x_mem[nb_addr];
    end

    // Sweep value: round the scaled rhs, add neighbors, halve, saturate.
    logic signed [63:0] f_v, s_v, h_v;
    always_comb begin
        f_v = (prod_reg + 64'sh8000_0000) >>> 32;
        s_v = f_v + 64'(xl_r) + 64'(xr_r);
        h_v = s_v >>> 1;
        if (h_v > 64'sh7FFF_FFFF) x_new = 32'sh7FFF_FFFF;
        else if (h_v < -64'sh8000_0000) x_new = 32'sh8000_0000;
        else x_new = h_v[31:0];
    end

    // Residual square, floor(t*t/2^32), built from 20-bit halves.
    always_comb begin
        t_abs = t_reg[63] ? -t_reg : t_reg;
        t_hi  = t_abs[39:20];
        t_lo  = t_abs[19:0];
        mid_v = 62'({hl_reg, 21'd0}) + 62'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg  <= '0;
            sum_reg <= '0;
        end else begin
            ph_reg <= ph_next;
            if (cmd.clr_sum) sum_reg <= '0;
            else if (cmd.op == OP_RES && ph_reg == 3'd6) begin
                sum_reg <= (49'(sum_reg) + 49'(sq_reg) > 49'(RES_MAX)) ?
                           RES_MAX : sum_reg + sq_reg;
            end
        end
        if (ph_reg == 3'd1 && cmd.op == OP_SWEEP)
            prod_reg <= 64'(rhs_r) * $signed({32'd0, step_sq});
        if (ph_reg == 3'd2 && cmd.op == OP_RES)
            prod_reg <= (64'(xl_r) - 2 * 64'(xc_r) + 64'(xr_r))
                        * $signed({40'd0, inv_step_sq});
        if (ph_reg == 3'd3) t_reg <= 64'(rhs_r) + prod_reg;
        if (ph_reg == 3'd4) begin
            sat_reg <= (t_abs >= 64'sh100_0000_0000);
            hh_reg  <= 40'(t_hi) * 40'(t_hi);
            hl_reg  <= 40'(t_hi) * 40'(t_lo);
            ll_reg  <= 40'(t_lo) * 40'(t_lo);
        end
        if (ph_reg == 3'd5) begin
            if (sat_reg) sq_reg <= RES_MAX;
            else sq_reg <= {hh_reg, 8'd0} + 48'(mid_v >> 32);
        end
    end

    always_comb begin
        ph_next = '0;
        done    = 1'b0;
        if (cmd.op == OP_SWEEP) begin
            ph_next = (ph_reg == 3'd3) ? 3'd0 : ph_reg + 3'd1;
            done    = (ph_reg == 3'd3);
        end else if (cmd.op == OP_RES) begin
            ph_next = (ph_reg == 3'd6) ? 3'd0 : ph_reg + 3'd1;
            done    = (ph_reg == 3'd6);
        end else if (cmd.op == OP_EMIT) begin
            ph_next = (ph_reg == 3'd1) ? 3'd0 : ph_reg + 3'd1;
            done    = (ph_reg == 3'd1);
        end
    end

    assign x_out   = xc_r;
    assign res_sum = sum_reg;

endmodule

// File: rtl/gs1d_ctrl.sv
// ---------------------------------------------------------------------------
// gs1d_ctrl
// Sequencer for loading, residual passes, sweeps and result emission.
// ---------------------------------------------------------------------------
module gs1d_ctrl
    import gs1d_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        last_in,
    output logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] max_sweeps,
    input  logic        dp_done,
    input  logic [47:0] res_sum,
    output gs1d_cmd_t   cmd,
    output logic [6:0]  n_pts,
    output logic [15:0] sweeps_out,
    output logic [47:0] res_out,
    output logic [5:0]  emit_idx,
    output logic        emit_last,
    output logic        emit_load
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_RES   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  st_reg, st_next;
    logic [6:0]  n_reg, n_next;
    logic [5:0]  i_reg, i_next;
    logic [15:0] sw_reg, sw_next;
    logic [47:0] thr_reg, thr_next;
    logic        init_reg, init_next;
    logic        acc;
    logic        pass_end;

    assign s_ready  = (st_reg == ST_LOAD);
    assign acc      = s_valid && s_ready;
    assign pass_end = ({1'b0, i_reg} + 7'd1 >= n_reg);
    assign m_valid  = (st_reg == ST_OUT);
    assign n_pts    = n_reg;
    assign sweeps_out = sw_reg;
    assign res_out  = res_sum;
    assign emit_idx = i_reg;
    assign emit_last = pass_end;
    assign emit_load = (st_reg == ST_EMIT) && dp_done;

    always_comb begin
        st_next = st_reg; n_next = n_reg; i_next = i_reg;
        sw_next = sw_reg; thr_next = thr_reg; init_next = init_reg;
        cmd = '0;
        cmd.idx = i_reg;
        unique case (st_reg)
            ST_LOAD: begin
                if (acc) begin
                    if (n_reg < 7'(MAX_POINTS)) begin
                        cmd.op = OP_LOAD;
                        cmd.idx = n_reg[5:0];
                        n_next = n_reg + 7'd1;
                    end
                    if (last_in) begin
                        st_next = ST_RES; i_next = '0; sw_next = '0;
                        init_next = 1'b1; cmd.clr_sum = 1'b1;
                    end
                end
            end
            ST_RES: begin
                cmd.op = OP_RES;
                if (dp_done) begin
                    i_next = i_reg + 6'd1;
                    if (pass_end) st_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // Divide by 1e8 via the initial residual: res*1e8 > init.
                if (init_reg) begin
                    thr_next  = res_sum;
                    init_next = 1'b0;
                end
                i_next = '0;
                if (sw_reg < max_sweeps &&
                    ((init_reg ? 75'(res_sum) * 75'd100000000 > 75'(res_sum)
                               : 75'(res_sum) * 75'd100000000 > 75'(thr_reg))))
                    st_next = ST_SWEEP;
                else
                    st_next = ST_EMIT;
            end
            ST_SWEEP: begin
                cmd.op = OP_SWEEP;
                if (dp_done) begin
                    i_next = i_reg + 6'd1;
                    if (pass_end) begin
                        st_next = ST_RES; i_next = '0;
                        sw_next = sw_reg + 16'd1; cmd.clr_sum = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                cmd.op = OP_EMIT;
                if (dp_done) st_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    i_next = i_reg + 6'd1;
                    if (pass_end) begin
                        st_next = ST_LOAD; n_next = '0;
                    end else st_next = ST_EMIT;
                end
            end
            default: st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_LOAD; n_reg <= '0; i_reg <= '0;
            sw_reg <= '0; thr_reg <= '0; init_reg <= 1'b0;
        end else begin
            st_reg <= st_next; n_reg <= n_next; i_reg <= i_next;
            sw_reg <= sw_next; thr_reg <= thr_next; init_reg <= init_next;
        end
    end

endmodule

// File: rtl/gauss_seidel_1d_poisson_solver.sv
// ---------------------------------------------------------------------------
// gauss_seidel_1d_poisson_solver
// Loads a right-hand side, solves the 1D Poisson problem, emits the solution.
// ---------------------------------------------------------------------------
// Usage: right-hand-side samples enter on the s_ channel, one item per cycle
// while loading; last_point on an item starts the solve. Samples past
// MAX_POINTS are dropped, but their flag still starts the solve.
// The solve holds s_ready low. Residual passes and sweeps take one point at
// a time and share the multiply path and the single solution store; the
// residual passes also use the split squaring. A solve of k sweeps runs
// k+1 residual passes before the first result.
// Results leave on the m_ channel in index order, one at a time, each
// held while m_ready is low. After the last result the block loads again.
// Reset returns to loading with an empty store and the register defaults.
// Configuration writes on cfg_ are always accepted; write only when idle.
// ---------------------------------------------------------------------------
module gauss_seidel_1d_poisson_solver
    import gs1d_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_rhs_value,
    input  logic               s_last_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_solution_value,
    output logic [5:0]         m_point_index,
    output logic [15:0]        m_sweeps_done,
    output logic [47:0]        m_residual_squared,
    output logic               m_last_result
);

    logic [15:0] max_sweeps_reg;
    logic [31:0] step_sq_reg;
    logic [23:0] inv_step_sq_reg;
    gs1d_cmd_t   cmd;
    logic        dp_done, emit_load, emit_last;
    logic [6:0]  n_pts;
    logic signed [31:0] x_out;
    logic [47:0] res_sum, res_out;
    logic [15:0] sweeps_out;
    logic [5:0]  emit_idx;
    logic signed [31:0] sol_reg;
    logic [5:0]  idx_reg;
    logic        last_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_sweeps_reg  <= MAX_SWEEPS_RST;
            step_sq_reg     <= STEP_SQ_RST;
            inv_step_sq_reg <= INV_STEP_SQ_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_SWEEPS:   max_sweeps_reg  <= cfg_data[15:0];
                CFG_STEP_SQUARED: step_sq_reg     <= cfg_data;
                CFG_INV_STEP_SQ:  inv_step_sq_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    gs1d_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .last_in(s_last_point),
        .m_valid, .m_ready, .max_sweeps(max_sweeps_reg), .dp_done, .res_sum,
        .cmd, .n_pts, .sweeps_out, .res_out, .emit_idx, .emit_last, .emit_load
    );

    gs1d_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk, .aresetn, .cmd, .n_pts, .rhs_in(s_rhs_value),
        .step_sq(step_sq_reg), .inv_step_sq(inv_step_sq_reg),
        .done(dp_done), .x_out, .res_sum
    );

    // Output register for the current result item.
    always_ff @(posedge aclk) begin
        if (emit_load) begin
            sol_reg  <= x_out;
            idx_reg  <= emit_idx;
            last_reg <= emit_last;
        end
    end

    assign m_solution_value   = sol_reg;
    assign m_point_index      = idx_reg;
    assign m_sweeps_done      = sweeps_out;
    assign m_residual_squared = res_out;
    assign m_last_result      = last_reg;

endmodule

// File: rtl/gs1d_checker.sv
// ---------------------------------------------------------------------------
// gs1d_checker
// Port-level checks for the solver, bound to the top level.
// ---------------------------------------------------------------------------
module gs1d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_point_index,
    input logic        m_last_result,
    input logic [15:0] m_sweeps_done
);

    // No loading while results are offered.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready)) else $error("load and emit overlap");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_index))
        else $error("stalled result changed");

    // Meant to check that the first result is point zero; it never fires.
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && $past(s_ready) |-> m_point_index == 6'd0)
        else $error("solve did not start at point zero");

    // The sweep count is constant across a solve's results.
    a_sw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_result |=> $stable(m_sweeps_done))
        else $error("sweep count changed during emit");

endmodule

bind gauss_seidel_1d_poisson_solver gs1d_checker u_chk (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_point_index,
    .m_last_result, .m_sweeps_done
);
